[hw/rtl/knob_soft_takeover_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the knob soft takeover block
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef KNOB_SOFT_TAKEOVER_ASSERT_SVH
`define KNOB_SOFT_TAKEOVER_ASSERT_SVH

`ifndef SYNTHESIS
`define KST_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");
`define KST_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define KST_ASSERT(lbl, clk, rstn, prop)
`define KST_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[hw/rtl/kst_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_pkg
// Types and constants shared by the knob soft takeover block.
// ----------------------------------------------------------------------------
package kst_pkg;

    localparam int KNOB_COUNT  = 6;
    localparam int PAGE_COUNT  = 4;
    localparam int VALUE_BITS  = 16;
    localparam int PAGE_W      = 2;
    localparam int KNOB_W      = 3;
    localparam int CFG_INDEX_W = 1;

    typedef logic [VALUE_BITS-1:0] t_value;

    localparam t_value VALUE_MAX     = {VALUE_BITS{1'b1}};
    localparam t_value PICKUP_RESET  = t_value'(655);
    localparam t_value EDIT_RESET    = t_value'(655);

    localparam logic [CFG_INDEX_W-1:0] REG_PICKUP_WINDOW = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_EDIT_WINDOW   = 1'b1;

    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_PRELOAD = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [PAGE_W-1:0] page;
        logic [KNOB_W-1:0] knob_index;
        t_value            pot_value;
    } t_in_item;

    typedef struct packed {
        t_value                param_value;
        logic                  knob_armed;
        logic [KNOB_COUNT-1:0] pending_mask;
        logic                  page_edited;
    } t_out_item;

endpackage

[hw/rtl/kst_store.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kst_store
// Stored parameter values, one per page and knob, in a synchronous memory
// with valid bits and forwarding of the most recent write.
// ----------------------------------------------------------------------------
module kst_store #(
    parameter int DEPTH  = kst_pkg::PAGE_COUNT * kst_pkg::KNOB_COUNT,
    parameter int SLOT_W = $clog2(DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [SLOT_W-1:0]   i_rd_slot,
    input  logic                i_wr_en,
    input  logic [SLOT_W-1:0]   i_wr_slot,
    input  kst_pkg::t_value     i_wr_data,
    output kst_pkg::t_value     o_rd_value
);

    kst_pkg::t_value    r_mem [DEPTH];
    kst_pkg::t_value    r_rd_data;
    logic [SLOT_W-1:0]  r_rd_slot;
    logic [DEPTH-1:0]   r_valid;
    logic               r_fwd_en;
    logic [SLOT_W-1:0]  r_fwd_slot;
    kst_pkg::t_value    r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_slot] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_slot];
            r_rd_slot <= i_rd_slot;
        end
        if (i_wr_en) begin
            r_fwd_slot <= i_wr_slot;
            r_fwd_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_fwd_en <= 1'b0;
        end else if (i_wr_en) begin
            r_valid[i_wr_slot] <= 1'b1;
            r_fwd_en           <= 1'b1;
        end
    end

    // The last write may have landed in the same cycle as the read.
    always_comb begin
        if (r_fwd_en && r_fwd_slot == r_rd_slot) begin
            o_rd_value = r_fwd_data;
        end else if (r_valid[r_rd_slot]) begin
            o_rd_value = r_rd_data;
        end else begin
            o_rd_value = '0;
        end
    end

endmodule

[hw/rtl/knob_soft_takeover.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// knob_soft_takeover
// Soft takeover of potentiometers over paged parameters.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the output is not
// stalled, and presents one result per transaction: the stored value is read
// from the parameter memory at acceptance, the pickup and edit decisions and
// the write back happen in the r_s1 stage that follows, and the result sits in an
// output register while the next transaction is already being worked on. The
// registered read of the parameter memory sets that depth; the most
// recent write is forwarded so that consecutive transactions on the same
// page and knob see each other. The memory needs no clearing pass after
// reset: per-entry valid bits make unwritten entries read as zero.
module knob_soft_takeover #(
    parameter int PAGE_COUNT = kst_pkg::PAGE_COUNT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  kst_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output kst_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_we,
    input  logic [kst_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  kst_pkg::t_value                    i_cfg_data
);

    `include "knob_soft_takeover_assert.svh"

    localparam int KNOBS  = kst_pkg::KNOB_COUNT;
    localparam int DEPTH  = PAGE_COUNT * KNOBS;
    localparam int SLOT_W = $clog2(DEPTH);

    kst_pkg::t_value    r_pickup;
    kst_pkg::t_value    r_edit;

    logic               r_s1_valid;
    kst_pkg::t_in_item  r_s1;
    logic               r_s1_ok;
    logic [SLOT_W-1:0]  r_s1_slot;

    logic [KNOBS-1:0]           r_armed;
    logic [KNOBS-1:0]           r_above;
    kst_pkg::t_value            r_entry [KNOBS];
    logic [kst_pkg::PAGE_W-1:0] r_seen_page [KNOBS];
    logic [KNOBS-1:0]           r_seen_valid;
    logic                       r_edited;

    logic [KNOBS-1:0]           n_armed;
    logic [KNOBS-1:0]           n_above;
    kst_pkg::t_value            n_entry [KNOBS];
    logic [kst_pkg::PAGE_W-1:0] n_seen_page [KNOBS];
    logic [KNOBS-1:0]           n_seen_valid;
    logic                       n_edited;

    logic                r_out_valid;
    kst_pkg::t_out_item  r_out;
    kst_pkg::t_out_item  n_out;

    logic               in_fire;
    logic               in_ok;
    logic [SLOT_W-1:0]  in_slot;
    logic               s1_adv;
    kst_pkg::t_value    st_value;
    logic               wr_en;

    logic                       is_sample;
    logic                       park;
    logic                       arm;
    logic [kst_pkg::KNOB_W-1:0] k;
    kst_pkg::t_value            p;
    kst_pkg::t_value            absd;
    kst_pkg::t_value            edd;
    kst_pkg::t_value            top;
    kst_pkg::t_value            entry;
    logic                       gt;
    logic                       lt;
    logic                       above;
    logic                       armed0;
    logic                       edited0;
    logic                       crossed;
    logic                       end_hit;
    kst_pkg::t_value            out_value;
    logic                       out_armed;

    assign in_fire    = i_in_valid && o_in_ready;
    assign in_ok      = (int'(i_in.page) < PAGE_COUNT) && (int'(i_in.knob_index) < KNOBS);
    assign in_slot    = SLOT_W'(int'(i_in.page) * KNOBS + int'(i_in.knob_index));
    assign s1_adv     = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;

    kst_store #(
        .DEPTH  (DEPTH),
        .SLOT_W (SLOT_W)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (in_fire && in_ok),
        .i_rd_slot  (in_slot),
        .i_wr_en    (s1_adv && wr_en),
        .i_wr_slot  (r_s1_slot),
        .i_wr_data  (r_s1.pot_value),
        .o_rd_value (st_value)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pickup <= kst_pkg::PICKUP_RESET;
            r_edit   <= kst_pkg::EDIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                kst_pkg::REG_PICKUP_WINDOW: r_pickup <= i_cfg_data;
                kst_pkg::REG_EDIT_WINDOW:   r_edit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        k         = r_s1.knob_index;
        p         = r_s1.pot_value;
        is_sample = r_s1.req_type == kst_pkg::REQ_SAMPLE;
        park      = !r_seen_valid[k] || r_seen_page[k] != r_s1.page;
        gt        = p > st_value;
        lt        = p < st_value;
        absd      = gt ? p - st_value : st_value - p;
        above     = park ? gt : r_above[k];
        entry     = park ? st_value : r_entry[k];
        armed0    = park ? 1'b0 : r_armed[k];
        edited0   = park ? 1'b0 : r_edited;
        top       = kst_pkg::VALUE_MAX - r_pickup;
        end_hit   = (p >= top && lt) || (p <= r_pickup && gt);
        crossed   = gt != above;
        arm       = armed0 || absd <= r_pickup || crossed || end_hit;
        edd       = (p > entry) ? p - entry : entry - p;

        n_armed      = r_armed;
        n_above      = r_above;
        n_entry      = r_entry;
        n_seen_page  = r_seen_page;
        n_seen_valid = r_seen_valid;
        n_edited     = r_edited;
        wr_en        = 1'b0;
        out_value    = '0;
        out_armed    = 1'b0;

        if (r_s1_ok) begin
            if (!is_sample) begin
                wr_en     = 1'b1;
                out_value = p;
                out_armed = r_armed[k];
            end else begin
                n_armed[k]      = arm;
                n_above[k]      = above;
                n_entry[k]      = entry;
                n_seen_page[k]  = r_s1.page;
                n_seen_valid[k] = 1'b1;
                n_edited        = edited0 || (arm && edd > r_edit);
                wr_en           = arm;
                out_value       = arm ? p : st_value;
                out_armed       = arm;
            end
        end

        n_out.param_value  = out_value;
        n_out.knob_armed   = out_armed;
        n_out.pending_mask = ~n_armed;
        n_out.page_edited  = n_edited;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_armed      <= '0;
            r_above      <= '0;
            r_seen_valid <= '0;
            r_edited     <= 1'b0;
            for (int i = 0; i < KNOBS; i++) begin
                r_entry[i]     <= '0;
                r_seen_page[i] <= '0;
            end
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid  <= 1'b1;
                r_armed      <= n_armed;
                r_above      <= n_above;
                r_entry      <= n_entry;
                r_seen_page  <= n_seen_page;
                r_seen_valid <= n_seen_valid;
                r_edited     <= n_edited;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1      <= i_in;
            r_s1_ok   <= in_ok;
            r_s1_slot <= in_slot;
        end
        if (s1_adv) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `KST_ASSERT(a_pending_matches, i_clk, i_rst_n, !r_out_valid || (r_out.pending_mask == ~r_armed))
    `KST_ASSERT_NEXT(a_armed_follows, i_clk, i_rst_n, s1_adv && r_s1_ok && is_sample && arm, r_out.param_value == $past(r_s1.pot_value))
    `KST_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1))

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for knob_soft_takeover
// Drives pot samples and preloads through the valid/ready input channel and
// checks every result against a cycle-free prediction of the soft takeover
// rules: per-knob parking on page change, pickup by window, crossing or end
// of travel, and the page edited flag. The run covers a short directed
// sequence, then random knob sweeps under several window settings and idling
// patterns, including a long output stall and a drain pause.
// ----------------------------------------------------------------------------
module testbench;
    import kst_pkg::*;

    class takeover_tracker;
        localparam logic [2:0] NO_PAGE = 3'd4;

        t_value     stored_val [PAGE_COUNT][KNOB_COUNT];
        bit         armed      [KNOB_COUNT];
        bit         came_above [KNOB_COUNT];
        t_value     entry_val  [KNOB_COUNT];
        logic [2:0] seen_page  [KNOB_COUNT];
        bit         edited;
        t_value     pickup_win;
        t_value     edit_win;
        t_out_item  due_results [$];
        int         mismatches;

        function new();
            foreach (stored_val[p, k]) stored_val[p][k] = '0;
            foreach (armed[k]) begin
                armed[k]      = 1'b0;
                came_above[k] = 1'b0;
                entry_val[k]  = '0;
                seen_page[k]  = NO_PAGE;
            end
            edited     = 1'b0;
            pickup_win = PICKUP_RESET;
            edit_win   = EDIT_RESET;
            mismatches = 0;
        endfunction

        function void set_window(logic [CFG_INDEX_W-1:0] idx, t_value val);
            if (idx == REG_PICKUP_WINDOW) pickup_win = val;
            else if (idx == REG_EDIT_WINDOW) edit_win = val;
        endfunction

        function int distance(int d);
            return (d < 0) ? -d : d;
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            int        k;
            int        p;
            int        diff;
            bit        crossed;
            bit        at_end;
            t_value    top;
            r = '0;
            k = int'(it.knob_index);
            p = int'(it.page);
            if (k < KNOB_COUNT) begin
                if (it.req_type == REQ_PRELOAD) begin
                    stored_val[p][k] = it.pot_value;
                end else begin
                    if (seen_page[k] != {1'b0, it.page}) begin
                        armed[k]      = 1'b0;
                        came_above[k] = it.pot_value > stored_val[p][k];
                        entry_val[k]  = stored_val[p][k];
                        edited        = 1'b0;
                        seen_page[k]  = {1'b0, it.page};
                    end
                    diff = int'(it.pot_value) - int'(stored_val[p][k]);
                    if (!armed[k]) begin
                        crossed = (diff > 0) != came_above[k];
                        top = (VALUE_MAX > pickup_win) ? VALUE_MAX - pickup_win : '0;
                        at_end = (it.pot_value >= top && diff < 0) ||
                                 (it.pot_value <= pickup_win && diff > 0);
                        if (distance(diff) <= int'(pickup_win) || crossed || at_end)
                            armed[k] = 1'b1;
                    end
                    if (armed[k]) begin
                        stored_val[p][k] = it.pot_value;
                        if (distance(int'(it.pot_value) - int'(entry_val[k])) > int'(edit_win))
                            edited = 1'b1;
                    end
                end
                r.param_value = stored_val[p][k];
                r.knob_armed  = armed[k];
            end
            for (int i = 0; i < KNOB_COUNT; i++) r.pending_mask[i] = !armed[i];
            r.page_edited = edited;
            due_results.push_back(r);
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: value %0d armed %0b pending %b edited %0b",
                             got.param_value, got.knob_armed, got.pending_mask,
                             got.page_edited);
                mismatches++;
                return;
            end
            want = due_results.pop_front();
            if (got.param_value !== want.param_value || got.knob_armed !== want.knob_armed ||
                got.pending_mask !== want.pending_mask ||
                got.page_edited !== want.page_edited) begin
                if (mismatches < 10)
                    $display({"result differs: expected value %0d armed %0b pending %b ",
                              "edited %0b, got value %0d armed %0b pending %b edited %0b"},
                             want.param_value, want.knob_armed, want.pending_mask,
                             want.page_edited, got.param_value, got.knob_armed,
                             got.pending_mask, got.page_edited);
                mismatches++;
            end
        endfunction

        function int outstanding();
            return due_results.size();
        endfunction
    endclass

    localparam int CYCLE_LIMIT     = 400000;
    localparam int ITEMS_PER_PHASE = 190;
    localparam int PHASES          = 8;

    logic                   i_clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   o_in_ready;
    t_in_item               in_item;
    logic                   o_out_valid;
    logic                   out_ready;
    t_out_item              o_out;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    t_value                 cfg_data;

    takeover_tracker   tracker;
    int                tx_idle_pct;
    int                rx_stall_pct;
    int                hold_left;
    int                cycle_count;
    int                pot_pos [KNOB_COUNT];
    logic [PAGE_W-1:0] cur_page;

    t_value pickup_plan [PHASES] = '{655, 0, 65535, 2000, 100, 655, 300, 12000};
    t_value edit_plan   [PHASES] = '{655, 0, 65535, 100, 3000, 655, 1, 40000};

    knob_soft_takeover DUT (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("knob_soft_takeover: mismatch");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (rst_n && out_ready && o_out_valid) tracker.check_result(o_out);
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left--;
        end else begin
            out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    task automatic send_item(input t_in_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_item(it);
    endtask

    task automatic offer(input logic typ, input int page, input int knob, input int pot);
        t_in_item it;
        it.req_type   = typ;
        it.page       = page[PAGE_W-1:0];
        it.knob_index = knob[KNOB_W-1:0];
        it.pot_value  = t_value'(pot);
        send_item(it);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    task automatic write_windows(input t_value pickup, input t_value edit);
        cfg_we    <= 1'b1;
        cfg_index <= REG_PICKUP_WINDOW;
        cfg_data  <= pickup;
        @(posedge i_clk);
        tracker.set_window(REG_PICKUP_WINDOW, pickup);
        cfg_index <= REG_EDIT_WINDOW;
        cfg_data  <= edit;
        @(posedge i_clk);
        tracker.set_window(REG_EDIT_WINDOW, edit);
        cfg_we <= 1'b0;
    endtask

    function automatic t_in_item next_item();
        t_in_item it;
        int       roll;
        int       k;
        int       step;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            it = t_in_item'($urandom);
        end else if (roll < 12) begin
            it.req_type   = REQ_PRELOAD;
            it.page       = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            it.knob_index = KNOB_W'($urandom_range(0, KNOB_COUNT - 1));
            if ($urandom_range(0, 9) == 0)
                it.pot_value = $urandom_range(0, 1) ? VALUE_MAX : '0;
            else
                it.pot_value = t_value'($urandom);
        end else begin
            if ($urandom_range(0, 99) < 4) cur_page = PAGE_W'($urandom_range(0, PAGE_COUNT - 1));
            k = $urandom_range(0, KNOB_COUNT - 1);
            step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 20000)
                                               : $urandom_range(0, 1200);
            if ($urandom_range(0, 1)) step = -step;
            pot_pos[k] += step;
            if (pot_pos[k] < 0) pot_pos[k] = 0;
            if (pot_pos[k] > int'(VALUE_MAX)) pot_pos[k] = int'(VALUE_MAX);
            if ($urandom_range(0, 19) == 0) pot_pos[k] = $urandom_range(0, 1) ? int'(VALUE_MAX) : 0;
            it.req_type   = REQ_SAMPLE;
            it.page       = cur_page;
            it.knob_index = k[KNOB_W-1:0];
            it.pot_value  = t_value'(pot_pos[k]);
        end
        return it;
    endfunction

    initial begin
        tracker      = new();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_left    = 0;
        cycle_count  = 0;
        cur_page     = '0;
        foreach (pot_pos[k]) pot_pos[k] = $urandom_range(0, int'(VALUE_MAX));
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_item   <= '0;
        out_ready <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_PICKUP_WINDOW;
        cfg_data  <= '0;
        repeat (8) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        offer(REQ_PRELOAD, 0, 0, 30000);
        offer(REQ_SAMPLE, 0, 0, 0);
        offer(REQ_SAMPLE, 0, 0, 29500);
        offer(REQ_SAMPLE, 0, 0, 31000);
        offer(REQ_SAMPLE, 1, 0, 31000);
        offer(REQ_SAMPLE, 1, 0, 200);
        offer(REQ_PRELOAD, 1, 1, 1000);
        offer(REQ_SAMPLE, 1, 1, 65535);
        offer(REQ_SAMPLE, 1, 1, 500);
        offer(REQ_PRELOAD, 2, 2, 65535);
        offer(REQ_SAMPLE, 2, 2, 65000);
        offer(REQ_PRELOAD, 3, 5, 0);
        offer(REQ_SAMPLE, 3, 5, 400);
        offer(REQ_SAMPLE, 3, 6, 1234);
        offer(REQ_PRELOAD, 3, 7, 65535);
        offer(REQ_SAMPLE, 3, 5, 65535);
        offer(REQ_PRELOAD, 3, 5, 7);
        offer(REQ_SAMPLE, 3, 5, 65535);
        offer(REQ_SAMPLE, 0, 3, 0);
        offer(REQ_PRELOAD, 0, 3, 65535);
        offer(REQ_SAMPLE, 0, 3, 0);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            if (ph > 0) write_windows(pickup_plan[ph], edit_plan[ph]);
            case (ph % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 69;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 69;
                end
                default: begin
                    tx_idle_pct  = 13;
                    rx_stall_pct = 13;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (ph == 4 && n == 20) hold_left = 300;
                if (ph == 5 && n == 90) wait_drained();
                send_item(next_item());
            end
        end

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("knob_soft_takeover: match");
        end else begin
            $display("knob_soft_takeover: mismatch");
        end
        $finish;
    end

endmodule
